### hdl/dual_ir_tape_pulse_timer_core_defines.svh
// Assertion macros for the file that checks its own logic.
`ifndef DUAL_IR_TAPE_PULSE_TIMER_CORE_DEFINES_SVH
`define DUAL_IR_TAPE_PULSE_TIMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DTPT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DTPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/dtpt_pkg.sv
package dtpt_pkg;

    localparam int TIME_BITS     = 32;
    localparam int OUT_BITS      = 32;
    localparam int DEB_BITS      = 20;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 1;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [DEB_BITS-1:0]  t_deb;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEBOUNCE_TICKS = 1'b0,
        CFG_MIN_HIGH_TIME  = 1'b1
    } t_cfg_idx;

    localparam t_deb                 DEBOUNCE_RESET = 20'd10000;
    localparam logic [OUT_BITS-1:0]  MIN_HIGH_RESET = 32'd1000;

    // What one lane reports to the merge stage for the current beat.
    typedef struct packed {
        logic  fire;        // settled level acted on this beat
        logic  low;         // settled level is tape
        logic  width_ok;    // candidate high time beats the minimum
        t_time cand_width;  // now minus stored entry
        t_time width;
        t_time gap;
        t_time entry;
    } t_lane_stat;

    typedef struct packed {
        logic [OUT_BITS-1:0] left_high_time;
        logic [OUT_BITS-1:0] right_high_time;
        logic [OUT_BITS-1:0] left_period;
        logic [OUT_BITS-1:0] right_period;
        logic [OUT_BITS-1:0] entry_skew;
    } t_result;

    function automatic logic [OUT_BITS-1:0] to_out(t_time v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_BITS-1:0];
    endfunction

endpackage

### hdl/dtpt_in_if.sv
interface dtpt_in_if;
    logic valid;
    logic ready;
    logic left_pin_level;
    logic right_pin_level;

    modport source (output valid, output left_pin_level, output right_pin_level,
                    input ready);
    modport sink   (input valid, input left_pin_level, input right_pin_level,
                    output ready);
endinterface

### hdl/dtpt_out_if.sv
interface dtpt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_high_time;
    logic [31:0] right_high_time;
    logic [31:0] left_period;
    logic [31:0] right_period;
    logic signed [31:0] entry_skew;

    modport source (output valid, output left_high_time, output right_high_time,
                    output left_period, output right_period, output entry_skew,
                    input ready);
    modport sink   (input valid, input left_high_time, input right_high_time,
                    input left_period, input right_period, input entry_skew,
                    output ready);
endinterface

### hdl/dtpt_lane.sv
module dtpt_lane (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic                    i_level,
    input  dtpt_pkg::t_time         i_now,
    input  dtpt_pkg::t_deb          i_debounce_ticks,
    input  logic [31:0]             i_min_high_time,
    output dtpt_pkg::t_lane_stat    o_stat
);
    import dtpt_pkg::*;

    logic  r_last_level, n_last_level;
    t_deb  r_wait, n_wait;
    logic  r_armed, n_armed;
    logic  fire_raw;
    t_time r_entry, r_width, r_gap;
    t_time cand;

    // Debounce countdown: any change restarts it, expiry acts once.
    always_comb begin
        n_last_level = r_last_level;
        n_wait       = r_wait;
        n_armed      = r_armed;
        fire_raw     = 1'b0;
        if (i_level != r_last_level) begin
            n_last_level = i_level;
            n_wait       = i_debounce_ticks;
            n_armed      = 1'b1;
        end else if (r_armed) begin
            if (r_wait <= DEB_BITS'(1)) begin
                n_wait   = '0;
                n_armed  = 1'b0;
                fire_raw = 1'b1;
            end else begin
                n_wait = r_wait - DEB_BITS'(1);
            end
        end
    end

    assign cand = i_now - r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b1;
            r_wait       <= '0;
            r_armed      <= 1'b0;
            r_entry      <= '0;
            r_width      <= '0;
            r_gap        <= '0;
        end else if (i_step) begin
            r_last_level <= n_last_level;
            r_wait       <= n_wait;
            r_armed      <= n_armed;
            if (fire_raw && !r_last_level) begin
                r_gap   <= cand;
                r_entry <= i_now;
            end else if (fire_raw) begin
                r_width <= cand;
            end
        end
    end

    assign o_stat.fire       = i_step & fire_raw;
    assign o_stat.low        = ~r_last_level;
    assign o_stat.width_ok   = 64'(cand) > 64'(i_min_high_time);
    assign o_stat.cand_width = cand;
    assign o_stat.width      = r_width;
    assign o_stat.gap        = r_gap;
    assign o_stat.entry      = r_entry;

endmodule

### hdl/dtpt_merge.sv
module dtpt_merge (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dtpt_pkg::t_lane_stat    i_left,
    input  dtpt_pkg::t_lane_stat    i_right,
    output logic                    o_emit,
    output logic                    o_emit_left,
    output logic                    o_emit_right,
    output dtpt_pkg::t_result       o_result
);
    import dtpt_pkg::*;

    logic r_left_ready, n_left_ready;
    logic r_right_ready, n_right_ready;
    logic left_hi, right_hi;
    logic rl1, rl2, rr2, rr3;
    t_time left_w, right_w;

    assign left_hi  = i_left.fire & ~i_left.low;
    assign right_hi = i_right.fire & ~i_right.low;

    // Left acts first, then right sees what left left behind.
    always_comb begin
        rl1 = i_left.fire ? (~i_left.low & i_left.width_ok) : r_left_ready;
        o_emit_left = left_hi & rl1 & r_right_ready;
        rl2 = o_emit_left ? 1'b0 : rl1;
        rr2 = o_emit_left ? 1'b0 : r_right_ready;
        rr3 = i_right.fire ? (~i_right.low & i_right.width_ok) : rr2;
        o_emit_right = right_hi & rl2 & rr3;
        n_left_ready  = o_emit_right ? 1'b0 : rl2;
        n_right_ready = o_emit_right ? 1'b0 : rr3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_ready  <= 1'b0;
            r_right_ready <= 1'b0;
        end else begin
            r_left_ready  <= n_left_ready;
            r_right_ready <= n_right_ready;
        end
    end

    assign left_w  = left_hi ? i_left.cand_width : i_left.width;
    assign right_w = o_emit_right ? i_right.cand_width : i_right.width;

    assign o_emit                   = o_emit_left | o_emit_right;
    assign o_result.left_high_time  = to_out(left_w);
    assign o_result.right_high_time = to_out(right_w);
    assign o_result.left_period     = to_out(i_left.gap);
    assign o_result.right_period    = to_out(i_right.gap);
    assign o_result.entry_skew      = to_out(i_right.entry) - to_out(i_left.entry);

endmodule

### hdl/dual_ir_tape_pulse_timer_core.sv
// Debounced pulse-width capture for two active-low tape sensors.
//
// Input channel (i_in_ch): one beat per microsecond tick carrying the raw
// left and right pin samples. Each accepted beat stamps the tick with the
// free-running time counter and advances it by one.
// Output channel (o_out_ch): one beat when both channels have a settled high
// time above the minimum: both high times, both periods and the signed
// right-minus-left entry skew.
// Config port: i_cfg_we / i_cfg_index / i_cfg_data, index 0 = debounce ticks,
// index 1 = minimum high time. Write only while the block is idle.
//
// Throughput: one input beat per cycle while the skid entry is empty. Both
// lanes debounce and subtract in parallel, the merge stage resolves ready
// flags in the same cycle. Results are registered before they reach o_out_ch.
// Stall: a main output register plus a one-entry skid register; input ready
// drops only while the skid entry is occupied, so one result may wait while
// input keeps flowing.
// Reset (synchronous, i_rst_n low): time counter, countdowns, entries, ready
// flags and output valids clear; pins are taken as pulled up; registers reload.
`include "dual_ir_tape_pulse_timer_core_defines.svh"

module dual_ir_tape_pulse_timer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    dtpt_in_if.sink                             i_in_ch,
    dtpt_out_if.source                          o_out_ch,
    input  logic                                i_cfg_we,
    input  logic [dtpt_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [dtpt_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import dtpt_pkg::*;

    t_time         r_time;
    t_deb          r_debounce_ticks;
    logic [31:0]   r_min_high_time;
    logic          step;
    t_lane_stat    left_stat, right_stat;
    logic          emit, emit_left, emit_right;
    t_result       result;

    logic          r_out_valid, r_skid_valid;
    t_result       r_out, r_skid;
    logic          push, pop;

    assign step = i_in_ch.valid & i_in_ch.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_RESET;
            r_min_high_time  <= MIN_HIGH_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data[DEB_BITS-1:0];
                CFG_MIN_HIGH_TIME:  r_min_high_time  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Free-running microsecond stamp: advance once per accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (step) begin
            r_time <= r_time + TIME_BITS'(1);
        end
    end

    dtpt_lane u_left (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_level          (i_in_ch.left_pin_level),
        .i_now            (r_time),
        .i_debounce_ticks (r_debounce_ticks),
        .i_min_high_time  (r_min_high_time),
        .o_stat           (left_stat)
    );

    dtpt_lane u_right (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_level          (i_in_ch.right_pin_level),
        .i_now            (r_time),
        .i_debounce_ticks (r_debounce_ticks),
        .i_min_high_time  (r_min_high_time),
        .o_stat           (right_stat)
    );

    // Merge: ready flags are only touched when a lane fires, which needs a beat.
    dtpt_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_left       (left_stat),
        .i_right      (right_stat),
        .o_emit       (emit),
        .o_emit_left  (emit_left),
        .o_emit_right (emit_right),
        .o_result     (result)
    );

    // Output register with one skid entry behind it.
    assign push = step & emit;
    assign pop  = r_out_valid & o_out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || pop) begin
            r_out_valid <= push;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || pop) begin
            r_out <= result;
        end else if (push) begin
            r_skid <= result;
        end
    end

    assign i_in_ch.ready            = ~r_skid_valid;
    assign o_out_ch.valid           = r_out_valid;
    assign o_out_ch.left_high_time  = r_out.left_high_time;
    assign o_out_ch.right_high_time = r_out.right_high_time;
    assign o_out_ch.left_period     = r_out.left_period;
    assign o_out_ch.right_period    = r_out.right_period;
    assign o_out_ch.entry_skew      = r_out.entry_skew;

    `DTPT_ASSERT_SAME(a_skid_behind_out, r_skid_valid, r_out_valid, "skid holds a beat with output empty")
    `DTPT_ASSERT_SAME(a_one_emit, emit_left, !emit_right, "both lanes emitted in one beat")
    `DTPT_ASSERT_NEXT(a_stall_to_skid, push && r_out_valid && !pop, r_skid_valid, "stalled result dropped")
    `DTPT_ASSERT_NEXT(a_time_step, step, r_time == $past(r_time) + TIME_BITS'(1), "time stamp did not advance")

endmodule

### tb/tb_dual_ir_tape_pulse_timer_core.sv
`timescale 1ns / 1ps

module tb_dual_ir_tape_pulse_timer_core;
    import dtpt_pkg::*;

    // Long receiver hold-off used to fill the output skid and stall the input.
    localparam int HOLD_OFF_CYCLES = 400;
    // Cycles to let pass after the last result before touching the registers.
    localparam int SETTLE_CYCLES   = 4;

    // Opening pattern, two bits per beat (left, right), sent from the top bits down:
    // glitch low on both pins from reset state, a clean pulse, a left pin that
    // toggles on every expiry tick, then right entering tape before left.
    localparam int            OPENING_BEATS = 19;
    localparam logic [37:0]   OPENING_PINS  = {
        2'b00, 2'b11, 2'b11,
        2'b00, 2'b00, 2'b11, 2'b11,
        2'b01, 2'b11, 2'b01, 2'b11,
        2'b10, 2'b10, 2'b00, 2'b00, 2'b01, 2'b01, 2'b11, 2'b11
    };

    typedef enum int {
        SIDE_LEFT  = 0,
        SIDE_RIGHT = 1
    } t_side;

    typedef struct packed {
        logic left;
        logic right;
    } t_pin_pair;

    // Per-sensor debounce and timing state.
    typedef struct packed {
        logic  level;
        t_deb  countdown;
        logic  armed;
        t_time entry;
        t_time width;
        t_time gap;
        logic  done;
    } t_pulse_lane;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    dtpt_in_if  in_ch ();
    dtpt_out_if out_ch ();

    dual_ir_tape_pulse_timer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted block state and register copies.
    t_pulse_lane lanes [2];
    t_time       tick_now;
    t_deb        debounce_setting;
    t_time       min_high_setting;

    t_pin_pair samples_to_send [$];
    t_result   reports_due [$];

    logic idling_on;
    int   hold_asks;
    int   hold_served;
    int   send_idle;
    int   recv_stall;
    int   beats_in;
    int   results_seen;
    int   mismatches;
    int   random_items;
    int   phases;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, well above the slowest legal run.
    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 'h%08h, expected 'h%08h", name, got, want));
    endtask

    function automatic void clear_lanes();
        foreach (lanes[i]) begin
            lanes[i]       = '0;
            lanes[i].level = 1'b1;  // pins pulled up out of reset
        end
        tick_now         = '0;
        debounce_setting = DEBOUNCE_RESET;
        min_high_setting = MIN_HIGH_RESET;
    endfunction

    // Restart the countdown on any change; report when the settled level is due.
    function automatic logic settle_lane(input t_side side, input logic pin);
        if (pin !== lanes[side].level) begin
            lanes[side].level     = pin;
            lanes[side].countdown = debounce_setting;
            lanes[side].armed     = 1'b1;
            return 1'b0;
        end
        if (!lanes[side].armed)
            return 1'b0;
        if (lanes[side].countdown <= 1) begin
            lanes[side].countdown = '0;
            lanes[side].armed     = 1'b0;
            return 1'b1;
        end
        lanes[side].countdown = lanes[side].countdown - 1'b1;
        return 1'b0;
    endfunction

    // Tape: stamp the entry and period. No tape: take the high time and emit
    // a report once both sensors hold one above the minimum.
    function automatic void apply_settled_level(input t_side side, input t_time now);
        t_result rep;
        if (lanes[side].level == 1'b0) begin
            lanes[side].gap   = now - lanes[side].entry;
            lanes[side].entry = now;
            lanes[side].done  = 1'b0;
        end else begin
            lanes[side].width = now - lanes[side].entry;
            lanes[side].done  = lanes[side].width > min_high_setting;
            if (lanes[SIDE_LEFT].done && lanes[SIDE_RIGHT].done) begin
                rep.left_high_time  = lanes[SIDE_LEFT].width;
                rep.right_high_time = lanes[SIDE_RIGHT].width;
                rep.left_period     = lanes[SIDE_LEFT].gap;
                rep.right_period    = lanes[SIDE_RIGHT].gap;
                rep.entry_skew      = lanes[SIDE_RIGHT].entry - lanes[SIDE_LEFT].entry;
                reports_due.push_back(rep);
                lanes[SIDE_LEFT].done  = 1'b0;
                lanes[SIDE_RIGHT].done = 1'b0;
            end
        end
    endfunction

    // One accepted beat is one microsecond tick; left acts before right.
    function automatic void predict_tick(input logic pin_l, input logic pin_r);
        t_time now;
        logic  act_l;
        logic  act_r;
        now   = tick_now;
        act_l = settle_lane(SIDE_LEFT, pin_l);
        act_r = settle_lane(SIDE_RIGHT, pin_r);
        if (act_l)
            apply_settled_level(SIDE_LEFT, now);
        if (act_r)
            apply_settled_level(SIDE_RIGHT, now);
        tick_now = now + 1'b1;
    endfunction

    // Sender: predict each accepted beat, then offer the next sample pair or idle.
    always @(posedge i_clk) begin : drive_pins
        t_pin_pair nxt;
        if (!i_rst_n) begin
            in_ch.valid           <= 1'b0;
            in_ch.left_pin_level  <= 1'b1;
            in_ch.right_pin_level <= 1'b1;
            send_idle = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_tick(in_ch.left_pin_level, in_ch.right_pin_level);
                beats_in++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_idle > 0) begin
                    send_idle--;
                    in_ch.valid <= 1'b0;
                end else if (idling_on && samples_to_send.size() != 0
                             && $urandom_range(0, 11) == 0) begin
                    // open an idle burst
                    send_idle = $urandom_range(0, 18);
                    in_ch.valid <= 1'b0;
                end else if (samples_to_send.size() != 0) begin
                    nxt = samples_to_send.pop_front();
                    in_ch.valid           <= 1'b1;
                    in_ch.left_pin_level  <= nxt.left;
                    in_ch.right_pin_level <= nxt.right;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted report against the oldest prediction,
    // then decide ready for the next cycle (long hold-off, stall burst or open).
    always @(posedge i_clk) begin : take_reports
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (reports_due.size() == 0) begin
                    report_mismatch($sformatf("report with none due, left high time %0d",
                                              out_ch.left_high_time));
                end else begin
                    want = reports_due.pop_front();
                    check_field("left_high_time", out_ch.left_high_time,
                                want.left_high_time);
                    check_field("right_high_time", out_ch.right_high_time,
                                want.right_high_time);
                    check_field("left_period", out_ch.left_period, want.left_period);
                    check_field("right_period", out_ch.right_period, want.right_period);
                    check_field("entry_skew", out_ch.entry_skew, want.entry_skew);
                end
            end
            if (hold_asks != hold_served) begin
                hold_served = hold_asks;
                recv_stall  = HOLD_OFF_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                recv_stall = $urandom_range(0, 18);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Hold until nothing is queued, in flight or owed, then let the block settle.
    task automatic wait_quiet();
        while (samples_to_send.size() != 0 || in_ch.valid || reports_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_DEBOUNCE_TICKS: debounce_setting = data[DEB_BITS-1:0];
            CFG_MIN_HIGH_TIME:  min_high_setting = data;
            default: ;
        endcase
    endtask

    task automatic queue_noise(output int count);
        t_pin_pair p;
        count = $urandom_range(1, 10);
        repeat (count) begin
            p.left  = $urandom_range(0, 1);
            p.right = $urandom_range(0, 1);
            samples_to_send.push_back(p);
        end
    endtask

    // One tape crossing: each pin drops low at its own offset for its own span,
    // then sits high long enough to settle. Occasional single-beat glitches.
    task automatic queue_pulse_pair(input int settle, output int count);
        int        start_l;
        int        start_r;
        int        low_l;
        int        low_r;
        t_pin_pair p;
        start_l = $urandom_range(0, settle + 3);
        start_r = $urandom_range(0, settle + 3);
        low_l   = $urandom_range(1, settle + 16);
        low_r   = $urandom_range(1, settle + 16);
        count   = start_l + low_l;
        if (start_r + low_r > count)
            count = start_r + low_r;
        count = count + settle + $urandom_range(1, 6);
        for (int t = 0; t < count; t++) begin
            p.left  = !(t >= start_l && t < start_l + low_l);
            p.right = !(t >= start_r && t < start_r + low_r);
            if ($urandom_range(0, 40) == 0)
                p.left = !p.left;
            if ($urandom_range(0, 40) == 0)
                p.right = !p.right;
            samples_to_send.push_back(p);
        end
    endtask

    task automatic run_random_phase(input logic [31:0] deb_data,
                                    input logic [31:0] min_data, input int goal);
        int queued;
        int n;
        int settle;
        wait_quiet();
        write_reg(CFG_DEBOUNCE_TICKS, deb_data);
        write_reg(CFG_MIN_HIGH_TIME, min_data);
        settle = (deb_data[DEB_BITS-1:0] == 0) ? 1 : int'(deb_data[DEB_BITS-1:0]);
        @(negedge i_clk);
        queued = 0;
        while (queued < goal) begin
            if ($urandom_range(0, 9) == 0)
                queue_noise(n);
            else
                queue_pulse_pair(settle, n);
            queued += n;
        end
        random_items += queued;
        phases++;
    endtask

    initial begin : stimulus
        logic [31:0] deb_data;
        logic [31:0] min_data;
        int          noise_n;
        t_pin_pair   p;

        // Known values on every input from time zero.
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_index           = CFG_DEBOUNCE_TICKS;
        i_cfg_data            = '0;
        in_ch.valid           = 1'b0;
        in_ch.left_pin_level  = 1'b1;
        in_ch.right_pin_level = 1'b1;
        out_ch.ready          = 1'b0;
        idling_on             = 1'b1;
        hold_asks             = 0;
        hold_served           = 0;
        beats_in              = 0;
        results_seen          = 0;
        mismatches            = 0;
        random_items          = 0;
        phases                = 0;
        clear_lanes();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset register values: a few beats, nothing may settle yet.
        for (int i = 0; i < 4; i++) begin
            p.left  = (i != 1) ? 1'b1 : 1'b0;
            p.right = (i != 2) ? 1'b1 : 1'b0;
            samples_to_send.push_back(p);
        end

        // Debounce written with only upper bits set, so it reads as zero
        // and must act like one tick; minimum high time at its floor.
        wait_quiet();
        write_reg(CFG_DEBOUNCE_TICKS, 32'hFFF0_0000);
        write_reg(CFG_MIN_HIGH_TIME, 32'd0);
        @(negedge i_clk);
        for (int i = OPENING_BEATS - 1; i >= 0; i--) begin
            p.left  = OPENING_PINS[2*i+1];
            p.right = OPENING_PINS[2*i];
            samples_to_send.push_back(p);
        end

        // Register ceilings: longest debounce, largest minimum.
        wait_quiet();
        write_reg(CFG_DEBOUNCE_TICKS, 32'h000F_FFFF);
        write_reg(CFG_MIN_HIGH_TIME, 32'hFFFF_FFFF);
        @(negedge i_clk);
        queue_noise(noise_n);
        queue_noise(noise_n);

        // Fill the block: clean pulses every four beats while the receiver
        // holds off, so the skid entry fills and input ready drops.
        wait_quiet();
        write_reg(CFG_DEBOUNCE_TICKS, 32'd1);
        write_reg(CFG_MIN_HIGH_TIME, 32'd0);
        @(negedge i_clk);
        hold_asks++;
        for (int i = 0; i < 240; i++) begin
            p.left  = i[1];
            p.right = i[1];
            samples_to_send.push_back(p);
        end

        // Random phases: mostly short debounce and small minimums so pulses
        // settle and reports come; sometimes zero debounce or an unreachable
        // minimum. Keep going until enough beats are queued or the phase cap is hit.
        while (random_items < 200 && phases < 60) begin
            case ($urandom_range(0, 5))
                0:       deb_data = $urandom() & 32'hFFF0_0000;
                1:       deb_data = 32'd1;
                default: deb_data = ($urandom() & 32'hFFF0_0000) | $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 7))
                0:       min_data = 32'd0;
                1:       min_data = 32'hFFFF_FFFF;
                default: min_data = $urandom_range(0, 12);
            endcase
            run_random_phase(deb_data, min_data, $urandom_range(60, 140));
        end

        // Closing stretch at full rate on both sides.
        wait_quiet();
        idling_on = 1'b0;
        run_random_phase($urandom_range(1, 3), $urandom_range(0, 6), 120);

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (reports_due.size() != 0)
            report_mismatch($sformatf("%0d reports never arrived", reports_due.size()));

        $display("run covered %0d pin beats (%0d random) over %0d random phases",
                 beats_in, random_items, phases);
        $display("%0d tape reports checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/dtpt_pkg.sv
hdl/dtpt_in_if.sv
hdl/dtpt_out_if.sv
hdl/dtpt_lane.sv
hdl/dtpt_merge.sv
hdl/dual_ir_tape_pulse_timer_core.sv
tb/tb_dual_ir_tape_pulse_timer_core.sv
